>>> rtl/mrpe_pkg.sv
// ----------------------------------------------------------------------------
// mrpe_pkg
// Shared types and constants of the memory region pool extractor.
// ----------------------------------------------------------------------------
package mrpe_pkg;

  localparam int unsigned MAP_AW = 16;  // widest map address
  localparam int unsigned ADDR_W = 17;  // address that can also hold the space size

  typedef enum logic [1:0] {
    CMD_PAINT = 2'd0,
    CMD_FETCH = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // Region kinds as given on the command channel
  typedef enum logic [1:0] {
    KIND_RAM      = 2'd0,
    KIND_RESERVED = 2'd1,
    KIND_REGISTER = 2'd2
  } kind_e;

  // Map entry codes, ordered by restrictiveness
  typedef enum logic [1:0] {
    CODE_NONE     = 2'd0,
    CODE_RAM      = 2'd1,
    CODE_RESERVED = 2'd2,
    CODE_REGISTER = 2'd3
  } code_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAINT,
    ST_SEEK,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic [MAP_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MAP_AW-1:0] wr_addr;
    code_e             wr_data;
  } map_req_t;

  // Kind to map code; the undefined kind saturates to register
  function automatic code_e kind_to_code(input logic [1:0] kind);
    code_e code;
    unique case (kind)
      KIND_RAM:      code = CODE_RAM;
      KIND_RESERVED: code = CODE_RESERVED;
      default:       code = CODE_REGISTER;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/mrpe_cmd_if.sv
// ----------------------------------------------------------------------------
// mrpe_cmd_if
// Command channel: paint, fetch and clear requests.
// ----------------------------------------------------------------------------
interface mrpe_cmd_if import mrpe_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] region_begin;
  logic [16:0] region_end;
  logic [1:0]  region_kind;

  modport source (output valid, command, region_begin, region_end, region_kind,
                  input ready);
  modport sink (input valid, command, region_begin, region_end, region_kind,
                output ready);
endinterface

>>> rtl/mrpe_run_if.sv
// ----------------------------------------------------------------------------
// mrpe_run_if
// Result channel: one RAM run or the done marker per fetch.
// ----------------------------------------------------------------------------
interface mrpe_run_if import mrpe_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [15:0] run_begin;
  logic [16:0] run_end;
  logic        pool;
  logic        done_res;

  modport source (output valid, run_begin, run_end, pool, done_res, input ready);
  modport sink (input valid, run_begin, run_end, pool, done_res, output ready);
endinterface

>>> rtl/mrpe_map_mem.sv
// ----------------------------------------------------------------------------
// mrpe_map_mem
// Coverage map: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mrpe_map_mem import mrpe_pkg::*; #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic     clk_i,
  input  map_req_t req_i,
  output code_e    rdata_o
);

  localparam int unsigned Aw = $clog2(DEPTH);

  code_e mem_q [DEPTH];
  code_e rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr[Aw-1:0]] <= req_i.wr_data;
    end
    rdata_q <= mem_q[req_i.rd_addr[Aw-1:0]];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mrpe_ctrl.sv
// ----------------------------------------------------------------------------
// mrpe_ctrl
// Sequencer: clear sweep, read-modify-write paint, run scan, result register.
// ----------------------------------------------------------------------------
module mrpe_ctrl import mrpe_pkg::*; #(
  parameter int unsigned ADDRESS_SPACE = 65536,
  parameter int unsigned ZERO_PAGE_END = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mrpe_cmd_if.sink      cmd_i,
  mrpe_run_if.source    run_o,
  output map_req_t      map_req_o,
  input  code_e         map_rdata_i
);

  localparam logic [ADDR_W-1:0] SpaceLim = ADDR_W'(ADDRESS_SPACE);
  localparam logic [ADDR_W-1:0] ZpLim    = ADDR_W'(ZERO_PAGE_END);

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [ADDR_W-1:0]  end_q, end_d;
  code_e              code_q, code_d;
  logic [ADDR_W-1:0]  cursor_q, cursor_d;
  logic [15:0]        begin_q, begin_d;
  logic               pool_q, pool_d;

  logic               out_valid_q, out_valid_d;
  logic [15:0]        out_begin_q, out_begin_d;
  logic [16:0]        out_end_q, out_end_d;
  logic               out_pool_q, out_pool_d;
  logic               out_done_q, out_done_d;

  logic               cmd_xfer;
  logic               slot_free;
  logic               is_ram;
  logic [ADDR_W-1:0]  end_sat;
  logic [ADDR_W-1:0]  run_limit;
  logic               seek_exhausted;
  logic               run_stop;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;
  assign slot_free   = !out_valid_q || run_o.ready;
  assign is_ram      = (map_rdata_i == CODE_RAM);
  assign end_sat     = (cmd_i.region_end > SpaceLim) ? SpaceLim : cmd_i.region_end;
  assign run_limit   = pool_q ? SpaceLim : ZpLim;
  // map read data always belongs to addr_q while scanning
  assign seek_exhausted = (addr_q >= SpaceLim);
  assign run_stop       = (addr_q >= run_limit) || !is_ram;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (addr_q >= SpaceLim - ADDR_W'(1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_xfer) begin
          priority if (cmd_i.command == CMD_PAINT) state_d = ST_PAINT;
          else if (cmd_i.command == CMD_FETCH)     state_d = ST_SEEK;
          else if (cmd_i.command == CMD_CLEAR)     state_d = ST_CLEAR;
          else                                     state_d = ST_IDLE;
        end
      end
      ST_PAINT: begin
        if (addr_q >= end_q) state_d = ST_IDLE;
      end
      ST_SEEK: begin
        if (seek_exhausted) begin
          if (slot_free) state_d = ST_IDLE;
        end else if (is_ram) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_stop && slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and map access
  always_comb begin
    addr_d      = addr_q;
    end_d       = end_q;
    code_d      = code_q;
    cursor_d    = cursor_q;
    begin_d     = begin_q;
    pool_d      = pool_q;
    out_valid_d = out_valid_q && !run_o.ready;
    out_begin_d = out_begin_q;
    out_end_d   = out_end_q;
    out_pool_d  = out_pool_q;
    out_done_d  = out_done_q;
    map_req_o.wr_en   = 1'b0;
    map_req_o.wr_addr = addr_q[MAP_AW-1:0];
    map_req_o.wr_data = CODE_NONE;

    unique case (state_q)
      ST_CLEAR: begin
        map_req_o.wr_en = 1'b1;
        addr_d          = addr_q + ADDR_W'(1);
        cursor_d        = '0;
      end
      ST_IDLE: begin
        if (cmd_xfer) begin
          priority if (cmd_i.command == CMD_PAINT) begin
            addr_d = {1'b0, cmd_i.region_begin};
            end_d  = end_sat;
            code_d = kind_to_code(cmd_i.region_kind);
          end else if (cmd_i.command == CMD_FETCH) begin
            addr_d = cursor_q;
          end else if (cmd_i.command == CMD_CLEAR) begin
            addr_d = '0;
          end else begin
            addr_d = addr_q;
          end
        end
      end
      ST_PAINT: begin
        if (addr_q < end_q) begin
          map_req_o.wr_en   = (map_rdata_i < code_q);
          map_req_o.wr_data = code_q;
          addr_d            = addr_q + ADDR_W'(1);
        end
      end
      ST_SEEK: begin
        if (seek_exhausted) begin
          if (slot_free) begin
            cursor_d    = SpaceLim;
            out_valid_d = 1'b1;
            out_begin_d = '0;
            out_end_d   = '0;
            out_pool_d  = 1'b0;
            out_done_d  = 1'b1;
          end
        end else begin
          if (is_ram) begin
            begin_d = addr_q[15:0];
            pool_d  = (addr_q >= ZpLim);
          end
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      ST_RUN: begin
        if (run_stop) begin
          if (slot_free) begin
            cursor_d    = addr_q;
            out_valid_d = 1'b1;
            out_begin_d = begin_q;
            out_end_d   = addr_q;
            out_pool_d  = pool_q;
            out_done_d  = 1'b0;
          end
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      default: ;
    endcase

    map_req_o.rd_addr = addr_d[MAP_AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q       <= end_d;
    code_q      <= code_d;
    begin_q     <= begin_d;
    pool_q      <= pool_d;
    out_begin_q <= out_begin_d;
    out_end_q   <= out_end_d;
    out_pool_q  <= out_pool_d;
    out_done_q  <= out_done_d;
  end

  assign run_o.valid     = out_valid_q;
  assign run_o.run_begin = out_begin_q;
  assign run_o.run_end   = out_end_q;
  assign run_o.pool      = out_pool_q;
  assign run_o.done_res  = out_done_q;

endmodule

>>> rtl/memory_region_pool_extractor_top.sv
// ----------------------------------------------------------------------------
// memory_region_pool_extractor_top
// Paints address regions into a coverage map and hands out pure RAM runs.
// ----------------------------------------------------------------------------
//  channel  dir  transfer carries
//  cmd_i    in   command, region_begin, region_end, region_kind
//  run_o    out  run_begin, run_end, pool, done_res (fetch only)
//
//  Paint: a pipelined read-modify-write of each address in the saturated
//  region, on the single map read port.
//  Fetch: a scan of the map addresses from the cursor; the scan is bound by
//  the one map read per cycle. Clear, and reset: a sweep writing every map
//  address, with cmd_i not ready. A fetch waits at its end while the result
//  register is full.
// ----------------------------------------------------------------------------
module memory_region_pool_extractor_top import mrpe_pkg::*; #(
  parameter int unsigned ADDRESS_SPACE = 65536,
  parameter int unsigned ZERO_PAGE_END = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrpe_cmd_if.sink    cmd_i,
  mrpe_run_if.source  run_o
);

  map_req_t map_req;
  code_e    map_rdata;

  mrpe_ctrl #(
    .ADDRESS_SPACE (ADDRESS_SPACE),
    .ZERO_PAGE_END (ZERO_PAGE_END)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .run_o       (run_o),
    .map_req_o   (map_req),
    .map_rdata_i (map_rdata)
  );

  mrpe_map_mem #(
    .DEPTH (ADDRESS_SPACE)
  ) u_map (
    .clk_i   (clk_i),
    .req_i   (map_req),
    .rdata_o (map_rdata)
  );

endmodule

>>> tb/tb_memory_region_pool_extractor_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_memory_region_pool_extractor_top
// Drives paint, fetch and clear commands into the extractor. A scoreboard
// keeps its own coverage map and scan cursor, predicts the RAM run or done
// marker for every accepted fetch, and checks each result transfer in order.
// ----------------------------------------------------------------------------
module tb_memory_region_pool_extractor_top import mrpe_pkg::*; ();

  localparam int unsigned SPACE       = 65536;
  localparam int unsigned ZP_END      = 256;
  localparam int unsigned TOP_BASE    = SPACE - 300;
  localparam int unsigned TAIL_CYCLES = SPACE + 16;
  // every item at a full map walk plus stalls, taken several times over
  localparam int unsigned CYCLE_LIMIT = 50_000_000;
  localparam int unsigned RAND_ITEMS  = 70;

  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam logic [1:0] KIND_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [15:0] run_begin;
    logic [16:0] run_end;
    logic        pool;
    logic        done_res;
  } run_t;

  class pool_scoreboard;
    code_e       cov_map [SPACE];
    int unsigned cursor;
    run_t        pending_runs [$];
    int unsigned errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (cov_map[i]) cov_map[i] = CODE_NONE;
      cursor = 0;
    endfunction

    function bit exhausted();
      return cursor == SPACE;
    endfunction

    function void note_command(logic [1:0] cmd, logic [15:0] rb, logic [16:0] re,
                               logic [1:0] kind);
      int unsigned a;
      int unsigned stop;
      int unsigned lim;
      code_e       code;
      run_t        run;
      case (cmd)
        CMD_PAINT: begin
          code = (kind == KIND_RAM) ? CODE_RAM :
                 (kind == KIND_RESERVED) ? CODE_RESERVED : CODE_REGISTER;
          stop = (32'(re) > SPACE) ? SPACE : 32'(re);
          for (a = 32'(rb); a < stop; a++)
            if (cov_map[a] < code) cov_map[a] = code;
        end
        CMD_CLEAR: wipe();
        CMD_FETCH: begin
          run = '0;
          a = cursor;
          while (a < SPACE && cov_map[a] != CODE_RAM) a++;
          if (a >= SPACE) begin
            cursor = SPACE;
            run.done_res = 1'b1;
          end else begin
            // runs never cross the zero-page boundary
            lim = (a < ZP_END) ? ZP_END : SPACE;
            stop = a;
            while (stop < lim && cov_map[stop] == CODE_RAM) stop++;
            cursor = stop;
            run.run_begin = a[15:0];
            run.run_end   = stop[16:0];
            run.pool      = (a >= ZP_END);
          end
          pending_runs.insert(pending_runs.size(), run);
        end
        default: ;
      endcase
    endfunction

    function void check_run(run_t got);
      run_t exp;
      if (pending_runs.size() == 0) begin
        if (errors < 10)
          $display("unexpected run: begin %h end %h pool %b done %b",
                   got.run_begin, got.run_end, got.pool, got.done_res);
        errors++;
        return;
      end
      exp = pending_runs.pop_front();
      if (got.run_begin !== exp.run_begin || got.run_end !== exp.run_end ||
          got.pool !== exp.pool || got.done_res !== exp.done_res) begin
        if (errors < 10)
          $display({"run mismatch: exp begin %h end %h pool %b done %b,",
                    " got begin %h end %h pool %b done %b"},
                   exp.run_begin, exp.run_end, exp.pool, exp.done_res,
                   got.run_begin, got.run_end, got.pool, got.done_res);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int unsigned cycle_count;

  mrpe_cmd_if cmd_bus ();
  mrpe_run_if run_bus ();

  pool_scoreboard sb = new();

  memory_region_pool_extractor_top #(
    .ADDRESS_SPACE(SPACE),
    .ZERO_PAGE_END(ZP_END)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .run_o (run_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // result side backpressure
  initial begin
    run_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      run_bus.ready = steady ? 1'b1 : ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && run_bus.valid && run_bus.ready)
      sb.check_run('{run_bus.run_begin, run_bus.run_end, run_bus.pool, run_bus.done_res});
  end

  task automatic send_command(input logic [1:0] cmd, input int unsigned rb,
                              input int unsigned re, input logic [1:0] kind);
    @(negedge clk_i);
    if (!steady && $urandom_range(99) < 21) begin
      cmd_bus.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    cmd_bus.command      = cmd;
    cmd_bus.region_begin = rb[15:0];
    cmd_bus.region_end   = re[16:0];
    cmd_bus.region_kind  = kind;
    cmd_bus.valid        = 1'b1;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    sb.note_command(cmd, rb[15:0], re[16:0], kind);
  endtask

  // valid must drop before any wait outside send_command
  task automatic drain_results();
    @(negedge clk_i);
    cmd_bus.valid = 1'b0;
    while (sb.pending_runs.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned rand_items;
    int unsigned phase;
    int unsigned base;
    int unsigned n;
    int unsigned pick;
    int unsigned rb;
    int unsigned re;
    int unsigned j;
    logic [1:0]  kind;

    rst_ni               = 1'b0;
    steady               = 1'b0;
    cmd_bus.valid        = 1'b0;
    cmd_bus.command      = CMD_PAINT;
    cmd_bus.region_begin = '0;
    cmd_bus.region_end   = '0;
    cmd_bus.region_kind  = KIND_RAM;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty map, boundary split, restriction order, saturation
    send_command(CMD_FETCH, 0, 0, KIND_RAM);
    send_command(CMD_FETCH, 'hFFFF, 'h1FFFF, KIND_UNDEFINED);
    send_command(CMD_CLEAR, 0, 0, KIND_RAM);
    send_command(CMD_PAINT, 0, 4, KIND_RAM);
    send_command(CMD_PAINT, 'h00F0, 'h0120, KIND_RAM);
    send_command(CMD_PAINT, 'h0110, 'h0112, KIND_RESERVED);
    send_command(CMD_PAINT, 'h0111, 'h0118, KIND_RAM);        // does not lower
    send_command(CMD_PAINT, 2, 3, KIND_UNDEFINED);            // acts as register
    send_command(CMD_PAINT, 'h0500, 'h0500, KIND_RAM);        // empty
    send_command(CMD_PAINT, 'h0600, 'h0010, KIND_REGISTER);   // begin past end
    send_command(CMD_PAINT, 'hFFF0, 'h1FFFF, KIND_RAM);       // end saturates
    send_command(CMD_PAINT, 'hFFF8, 'h0FFFA, KIND_RESERVED);
    send_command(CMD_PAINT, 'hFFFF, 'h1FFFF, KIND_RAM);
    send_command(CMD_UNUSED, 'h1234, 'h05678, KIND_RAM);
    send_command(CMD_FETCH, 0, 0, KIND_RAM);
    send_command(CMD_FETCH, 0, 0, KIND_RAM);
    send_command(CMD_FETCH, 0, 0, KIND_RAM);
    send_command(CMD_FETCH, 0, 0, KIND_RAM);
    send_command(CMD_PAINT, 'h0010, 'h0014, KIND_RAM);        // behind cursor
    send_command(CMD_PAINT, 'h0200, 'h0208, KIND_RAM);        // ahead of cursor
    send_command(CMD_FETCH, 0, 0, KIND_RAM);
    send_command(CMD_FETCH, 0, 0, KIND_RAM);
    send_command(CMD_FETCH, 0, 0, KIND_RAM);
    send_command(CMD_FETCH, 0, 0, KIND_RAM);
    send_command(CMD_FETCH, 0, 0, KIND_RAM);

    // random phases: clear, paint a window, fetch runs out of it
    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      drain_results();
      steady = (phase == 2);
      send_command(CMD_CLEAR, $urandom, $urandom, 2'($urandom));
      rand_items++;
      case ($urandom_range(2))
        0:       base = 0;
        1:       base = $urandom_range(0, SPACE - 600);
        default: base = TOP_BASE;
      endcase
      n = $urandom_range(6, 12);
      for (int i = 0; i < n; i++) begin
        pick = (i < 3) ? 0 : $urandom_range(99);
        if (pick < 45) begin
          rb = base + $urandom_range(0, 255);
          re = rb + $urandom_range(0, 40);
          if (base == TOP_BASE && $urandom_range(3) == 0)
            re = $urandom_range(SPACE, 'h1FFFF);
          kind = (i < 3 || $urandom_range(99) < 55) ? KIND_RAM : 2'($urandom_range(1, 3));
          send_command(CMD_PAINT, rb, re, kind);
          if (re > rb) rand_items++;
        end else if (pick < 82) begin
          send_command(CMD_FETCH, $urandom, $urandom, 2'($urandom));
          rand_items++;
        end else if (pick < 92) begin
          rb = $urandom_range(0, SPACE - 1);
          send_command(CMD_PAINT, rb, $urandom_range(0, rb), 2'($urandom));
        end else if (pick < 97) begin
          send_command(CMD_UNUSED, $urandom, $urandom, 2'($urandom));
        end else begin
          // wide region anywhere, may walk most of the map
          rb = $urandom_range(0, SPACE - 1);
          send_command(CMD_PAINT, rb, $urandom_range(rb, 'h1FFFF), 2'($urandom));
          rand_items++;
        end
      end
      if ($urandom_range(2) == 0) begin
        j = 0;
        while (!sb.exhausted() && j < 40) begin
          send_command(CMD_FETCH, $urandom, $urandom, 2'($urandom));
          rand_items++;
          j++;
        end
        send_command(CMD_FETCH, $urandom, $urandom, 2'($urandom));
        rand_items++;
      end
      phase++;
    end
    steady = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_runs.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
